// ----- rtl/slm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_pkg
// Types and constants shared by the supply level monitor files.
// ----------------------------------------------------------------------------
package slm_pkg;

    typedef logic [2:0]  t_level;
    typedef logic [15:0] t_mv;
    typedef logic [11:0] t_margin;

    localparam t_level LVL_UNKNOWN = 3'd0;
    localparam t_level LVL_NORMAL  = 3'd1;
    localparam t_level LVL_OWE     = 3'd2;
    localparam t_level LVL_LOW     = 3'd3;
    localparam t_level LVL_CUT     = 3'd4;

    // APB register map, index = paddr[4:2]
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [2:0] REG_OWE   = 3'd0;
    localparam logic [2:0] REG_LOW   = 3'd1;
    localparam logic [2:0] REG_CUT   = 3'd2;
    localparam logic [2:0] REG_HYS   = 3'd3;
    localparam logic [2:0] REG_START = 3'd4;

    localparam t_mv     RST_OWE   = 16'd3300;
    localparam t_mv     RST_LOW   = 16'd3000;
    localparam t_mv     RST_CUT   = 16'd2700;
    localparam t_margin RST_HYS   = 12'd50;
    localparam t_mv     RST_START = 16'd3000;

endpackage

// ----- rtl/slm_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_stream_if
// Valid/ready channels for supply samples and level results.
// ----------------------------------------------------------------------------
interface slm_sample_if;
    logic            valid;
    logic            ready;
    slm_pkg::t_mv    sample_mv;
    logic            link_busy;

    modport source (output valid, output sample_mv, output link_busy, input ready);
    modport sink   (input valid, input sample_mv, input link_busy, output ready);
endinterface

interface slm_result_if;
    logic            valid;
    logic            ready;
    slm_pkg::t_level level;
    logic            changed;
    slm_pkg::t_level from_level;
    logic            power_off_event;
    logic            power_on_event;

    modport source (output valid, output level, output changed, output from_level,
                    output power_off_event, output power_on_event, input ready);
    modport sink   (input valid, input level, input changed, input from_level,
                    input power_off_event, input power_on_event, output ready);
endinterface

// ----- rtl/supply_level_monitor_hysteresis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_level_monitor_hysteresis
// Sorts supply samples into normal/owe/low/cut levels with hysteresis,
// busy suppression and repeat-to-commit filtering.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries one supply sample (mV) and a link-busy flag per transfer.
//   o_result returns exactly one result per sample: committed level, change
//   flag, previous level and power off/on events.
//   Thresholds and margin sit behind an APB port (owe 0x00, low 0x04,
//   cut 0x08, margin 0x0C, start 0x10); write them only while idle.
// Flow: a sample lands in the input register on transfer, is classified and
//   committed into the result register once it is empty or being taken, and
//   is presented from then on. Throughput: one sample per cycle while results
//   are taken, set by the single classify-and-commit stage between registers.
// Stall: while the result is not taken, the input register still fills once,
//   then i_sample.ready drops until the result transfers.
// Reset: level returns to unknown, the repeat counter clears and the
//   registers take their default thresholds.
// ----------------------------------------------------------------------------
module supply_level_monitor_hysteresis (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    slm_sample_if.sink                    i_sample,
    slm_result_if.source                  o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slm_pkg::ADDR_W-1:0]    paddr,
    input  logic [slm_pkg::DATA_W-1:0]    pwdata,
    output logic [slm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // ---------------- configuration ----------------
    slm_pkg::t_mv     r_owe, r_low, r_cut, r_start;
    slm_pkg::t_margin r_hys;
    logic [2:0]       w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owe   <= slm_pkg::RST_OWE;
            r_low   <= slm_pkg::RST_LOW;
            r_cut   <= slm_pkg::RST_CUT;
            r_hys   <= slm_pkg::RST_HYS;
            r_start <= slm_pkg::RST_START;
        end else if (w_wr) begin
            unique case (w_idx)
                slm_pkg::REG_OWE:   r_owe   <= pwdata[15:0];
                slm_pkg::REG_LOW:   r_low   <= pwdata[15:0];
                slm_pkg::REG_CUT:   r_cut   <= pwdata[15:0];
                slm_pkg::REG_HYS:   r_hys   <= pwdata[11:0];
                slm_pkg::REG_START: r_start <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            slm_pkg::REG_OWE:   prdata = {16'd0, r_owe};
            slm_pkg::REG_LOW:   prdata = {16'd0, r_low};
            slm_pkg::REG_CUT:   prdata = {16'd0, r_cut};
            slm_pkg::REG_HYS:   prdata = {20'd0, r_hys};
            slm_pkg::REG_START: prdata = {16'd0, r_start};
            default:            prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic             r_in_vld, r_out_vld;
    slm_pkg::t_mv     r_in_smp;
    logic             r_in_busy;
    logic             w_adv;

    assign w_adv          = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_sample.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_vld <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.ready && i_sample.valid) begin
            r_in_smp  <= i_sample.sample_mv;
            r_in_busy <= i_sample.link_busy;
        end
    end

    // ---------------- classification ----------------
    // 18-bit signed so threshold +/- margin never wraps
    logic signed [17:0] w_s, w_own, w_lowt, w_cutt, w_m;

    assign w_s    = $signed({2'b00, r_in_smp});
    assign w_own  = $signed({2'b00, r_owe});
    assign w_lowt = $signed({2'b00, r_low});
    assign w_cutt = $signed({2'b00, r_cut});
    assign w_m    = $signed({6'd0, r_hys});

    slm_pkg::t_level r_cur, r_cand;
    logic [1:0]      r_cnt;

    slm_pkg::t_level w_direct, w_target;

    always_comb begin
        priority if (w_s > w_own)  w_direct = slm_pkg::LVL_NORMAL;
        else if (w_s > w_lowt)     w_direct = slm_pkg::LVL_OWE;
        else if (w_s > w_cutt)     w_direct = slm_pkg::LVL_LOW;
        else                       w_direct = slm_pkg::LVL_CUT;
    end

    always_comb begin
        w_target = r_cur;
        unique case (r_cur)
            slm_pkg::LVL_NORMAL: begin
                priority if (w_s <= w_own - w_m && w_s > w_lowt)
                    w_target = r_in_busy ? r_cur : slm_pkg::LVL_OWE;
                else if (w_s <= w_lowt && w_s > w_cutt)
                    w_target = r_in_busy ? r_cur : slm_pkg::LVL_LOW;
                else if (w_s <= w_cutt)
                    w_target = slm_pkg::LVL_CUT;
                else
                    w_target = r_cur;
            end
            slm_pkg::LVL_OWE: begin
                priority if (w_s > w_own + w_m)
                    w_target = slm_pkg::LVL_NORMAL;
                else if (w_s <= w_lowt - w_m && w_s > w_cutt)
                    w_target = r_in_busy ? r_cur : slm_pkg::LVL_LOW;
                else if (w_s <= w_cutt)
                    w_target = slm_pkg::LVL_CUT;
                else
                    w_target = r_cur;
            end
            slm_pkg::LVL_LOW: begin
                priority if (w_s > w_own)       w_target = slm_pkg::LVL_NORMAL;
                else if (w_s > w_lowt + w_m)    w_target = slm_pkg::LVL_OWE;
                else if (w_s <= w_cutt - w_m)   w_target = slm_pkg::LVL_CUT;
                else                            w_target = r_cur;
            end
            slm_pkg::LVL_CUT: begin
                priority if (w_s > w_own)       w_target = slm_pkg::LVL_NORMAL;
                else if (w_s > w_lowt)          w_target = slm_pkg::LVL_OWE;
                else if (w_s > w_cutt + w_m)    w_target = slm_pkg::LVL_LOW;
                else                            w_target = r_cur;
            end
            default: w_target = r_cur;
        endcase
    end

    // ---------------- commit ----------------
    slm_pkg::t_level n_cur, n_cand;
    logic [1:0]      n_cnt;
    logic            n_chg;
    logic [1:0]      w_need;

    // normal->owe and owe->low need two samples in a row
    assign w_need = ((r_cur == slm_pkg::LVL_NORMAL && w_target == slm_pkg::LVL_OWE) ||
                     (r_cur == slm_pkg::LVL_OWE && w_target == slm_pkg::LVL_LOW))
                    ? 2'd2 : 2'd1;

    always_comb begin
        n_cur  = r_cur;
        n_cand = r_cand;
        n_cnt  = r_cnt;
        n_chg  = 1'b0;
        if (r_cur == slm_pkg::LVL_UNKNOWN) begin
            if (r_in_smp >= r_start) begin
                n_cur  = w_direct;
                n_cand = w_direct;
                n_cnt  = 2'd0;
                n_chg  = 1'b1;
            end
        end else if (w_target != r_cur) begin
            if (w_target == r_cand) begin
                n_cnt = (r_cnt == 2'd3) ? r_cnt : r_cnt + 2'd1;
            end else begin
                n_cand = w_target;
                n_cnt  = 2'd1;
            end
            if (n_cnt >= w_need) begin
                n_cnt  = 2'd0;
                n_cur  = w_target;
                n_cand = w_target;
                n_chg  = 1'b1;
            end
        end else begin
            n_cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= slm_pkg::LVL_UNKNOWN;
            r_cand <= slm_pkg::LVL_UNKNOWN;
            r_cnt  <= 2'd0;
        end else if (w_adv) begin
            r_cur  <= n_cur;
            r_cand <= n_cand;
            r_cnt  <= n_cnt;
        end
    end

    // ---------------- result register ----------------
    slm_pkg::t_level r_o_level, r_o_from;
    logic            r_o_chg, r_o_off, r_o_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_level <= n_cur;
            r_o_from  <= r_cur;
            r_o_chg   <= n_chg;
            r_o_off   <= n_chg && (n_cur == slm_pkg::LVL_CUT) &&
                         (r_cur != slm_pkg::LVL_UNKNOWN);
            r_o_on    <= n_chg && (r_cur == slm_pkg::LVL_CUT);
        end
    end

    assign o_result.valid           = r_out_vld;
    assign o_result.level           = r_o_level;
    assign o_result.changed         = r_o_chg;
    assign o_result.from_level      = r_o_from;
    assign o_result.power_off_event = r_o_off;
    assign o_result.power_on_event  = r_o_on;

    // ---------------- assertions ----------------
    a_level_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_o_level == r_cur))
        else $error("pending result level differs from committed level");

    a_unknown_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur == slm_pkg::LVL_UNKNOWN) |-> (r_cnt == 2'd0))
        else $error("repeat counter nonzero while level unknown");

    a_events_need_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_o_off || r_o_on)) |-> (r_o_chg && !(r_o_off && r_o_on)))
        else $error("power event without a single committed change");

    a_change_moves_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_o_chg) |-> (r_o_level != r_o_from))
        else $error("change flagged but level unchanged");

endmodule

// ----- bench/tb_supply_level_monitor_hysteresis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_supply_level_monitor_hysteresis
// Self-checking bench for the supply level monitor. A clocked driver feeds
// samples from a pending queue. Every accepted sample runs through a local
// level predictor, and the monitor compares each result transfer with the
// oldest prediction. Phases change thresholds over APB while the block is
// idle, and they change the source/sink idle pattern.
// ----------------------------------------------------------------------------
module tb_supply_level_monitor_hysteresis;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_MAX    = 10;
    localparam int MATCH_SAT     = 3;    // repeat counter saturates here
    localparam int NEED_SLOW     = 2;    // normal->owe and owe->low
    localparam int NEED_FAST     = 1;
    localparam int REG_IDX_MAX   = 7;    // top index reachable through paddr[4:2]
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 94;
    localparam int ADDR_BITS     = slm_pkg::ADDR_W;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} t_idle_mode;

    typedef struct {
        slm_pkg::t_mv mv;
        logic         busy;
    } t_sample_item;

    typedef struct {
        slm_pkg::t_level level;
        logic            changed;
        slm_pkg::t_level from_level;
        logic            pwr_off;
        logic            pwr_on;
    } t_level_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [slm_pkg::ADDR_W-1:0]  paddr;
    logic [slm_pkg::DATA_W-1:0]  pwdata;
    logic [slm_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    slm_sample_if smp ();
    slm_result_if res ();

    supply_level_monitor_hysteresis uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp),
        .o_result (res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor copy of the registers and level state
    slm_pkg::t_mv     owe_thr   = slm_pkg::RST_OWE;
    slm_pkg::t_mv     low_thr   = slm_pkg::RST_LOW;
    slm_pkg::t_mv     cut_thr   = slm_pkg::RST_CUT;
    slm_pkg::t_margin hys_mrg   = slm_pkg::RST_HYS;
    slm_pkg::t_mv     start_thr = slm_pkg::RST_START;
    slm_pkg::t_level  cur_lvl   = slm_pkg::LVL_UNKNOWN;
    slm_pkg::t_level  cand_lvl  = slm_pkg::LVL_UNKNOWN;
    int               match_cnt = 0;

    t_sample_item  pending_samples[$];
    t_level_result expected_levels[$];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int cycle_cnt = 0;
    int mismatch_cnt = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_changes = 0;
    int n_pwr_off = 0;
    int n_pwr_on = 0;

    t_sample_item  drv_item;
    t_level_result chk_exp;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic slm_pkg::t_level classify_first(int s);
        if (s > int'(owe_thr)) return slm_pkg::LVL_NORMAL;
        if (s > int'(low_thr)) return slm_pkg::LVL_OWE;
        if (s > int'(cut_thr)) return slm_pkg::LVL_LOW;
        return slm_pkg::LVL_CUT;
    endfunction

    function automatic slm_pkg::t_level classify_known(slm_pkg::t_level cur, int s,
                                                       logic busy);
        int own;
        int lowt;
        int cutt;
        int m;
        own  = int'(owe_thr);
        lowt = int'(low_thr);
        cutt = int'(cut_thr);
        m    = int'(hys_mrg);
        case (cur)
            slm_pkg::LVL_NORMAL: begin
                if (s <= own - m && s > lowt) return busy ? cur : slm_pkg::LVL_OWE;
                if (s <= lowt && s > cutt) return busy ? cur : slm_pkg::LVL_LOW;
                if (s <= cutt) return slm_pkg::LVL_CUT;
                return cur;
            end
            slm_pkg::LVL_OWE: begin
                if (s > own + m) return slm_pkg::LVL_NORMAL;
                if (s <= lowt - m && s > cutt) return busy ? cur : slm_pkg::LVL_LOW;
                if (s <= cutt) return slm_pkg::LVL_CUT;
                return cur;
            end
            slm_pkg::LVL_LOW: begin
                if (s > own) return slm_pkg::LVL_NORMAL;
                if (s > lowt + m) return slm_pkg::LVL_OWE;
                if (s <= cutt - m) return slm_pkg::LVL_CUT;
                return cur;
            end
            slm_pkg::LVL_CUT: begin
                if (s > own) return slm_pkg::LVL_NORMAL;
                if (s > lowt) return slm_pkg::LVL_OWE;
                if (s > cutt + m) return slm_pkg::LVL_LOW;
                return cur;
            end
            default: return cur;
        endcase
    endfunction

    task automatic predict_level(input slm_pkg::t_mv mv, input logic busy);
        t_level_result   r;
        slm_pkg::t_level tgt;
        int              s;
        int              need;
        s = int'(mv);
        r.from_level = cur_lvl;
        r.changed = 1'b0;
        if (cur_lvl == slm_pkg::LVL_UNKNOWN) begin
            if (s >= int'(start_thr)) begin
                cur_lvl = classify_first(s);
                cand_lvl = cur_lvl;
                match_cnt = 0;
                r.changed = 1'b1;
            end
        end else begin
            tgt = classify_known(cur_lvl, s, busy);
            if (tgt != cur_lvl) begin
                if (tgt == cand_lvl) begin
                    if (match_cnt < MATCH_SAT) match_cnt++;
                end else begin
                    cand_lvl = tgt;
                    match_cnt = 1;
                end
                need = ((cur_lvl == slm_pkg::LVL_NORMAL && tgt == slm_pkg::LVL_OWE) ||
                        (cur_lvl == slm_pkg::LVL_OWE && tgt == slm_pkg::LVL_LOW))
                       ? NEED_SLOW : NEED_FAST;
                if (match_cnt >= need) begin
                    match_cnt = 0;
                    cur_lvl = tgt;
                    cand_lvl = tgt;
                    r.changed = 1'b1;
                end
            end else begin
                match_cnt = 0;
            end
        end
        r.level = cur_lvl;
        r.pwr_off = r.changed && cur_lvl == slm_pkg::LVL_CUT &&
                    r.from_level != slm_pkg::LVL_UNKNOWN;
        r.pwr_on = r.changed && r.from_level == slm_pkg::LVL_CUT;
        expected_levels.push_back(r);
    endtask

    // ------------------------------------------------------------------- driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else begin
            if (smp.valid && smp.ready) begin
                predict_level(smp.sample_mv, smp.link_busy);
                n_accepted++;
            end
            if (!smp.valid || smp.ready) begin
                if (pending_samples.size() > 0 &&
                    int'($urandom_range(99)) >= src_idle_pct) begin
                    drv_item = pending_samples.pop_front();
                    smp.valid <= 1'b1;
                    smp.sample_mv <= drv_item.mv;
                    smp.link_busy <= drv_item.busy;
                end else begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------ monitor
    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (expected_levels.size() == 0) begin
                    note_mismatch($sformatf("result with nothing expected: level=%0d chg=%0b",
                                            res.level, res.changed));
                end else begin
                    chk_exp = expected_levels.pop_front();
                    n_checked++;
                    if (chk_exp.changed) n_changes++;
                    if (chk_exp.pwr_off) n_pwr_off++;
                    if (chk_exp.pwr_on) n_pwr_on++;
                    if (res.level !== chk_exp.level || res.changed !== chk_exp.changed ||
                        res.from_level !== chk_exp.from_level ||
                        res.power_off_event !== chk_exp.pwr_off ||
                        res.power_on_event !== chk_exp.pwr_on) begin
                        note_mismatch({
                            $sformatf("exp lvl=%0d chg=%0b from=%0d off=%0b on=%0b",
                                      chk_exp.level, chk_exp.changed, chk_exp.from_level,
                                      chk_exp.pwr_off, chk_exp.pwr_on),
                            $sformatf(", got lvl=%0d chg=%0b from=%0d off=%0b on=%0b",
                                      res.level, res.changed, res.from_level,
                                      res.power_off_event, res.power_on_event)});
                    end
                end
            end
            res.ready <= (int'($urandom_range(99)) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_levels.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------ helpers
    task automatic write_reg(input int idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'(idx * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            int'(slm_pkg::REG_OWE):   owe_thr = value[15:0];
            int'(slm_pkg::REG_LOW):   low_thr = value[15:0];
            int'(slm_pkg::REG_CUT):   cut_thr = value[15:0];
            int'(slm_pkg::REG_HYS):   hys_mrg = value[11:0];
            int'(slm_pkg::REG_START): start_thr = value[15:0];
            default: ;
        endcase
    endtask

    // upper bits are junk on purpose; the block masks to register width
    task automatic set_thresholds(input int owe, input int low, input int cut,
                                  input int hys, input int start);
        write_reg(int'(slm_pkg::REG_OWE),   ($urandom() & 32'hFFFF_0000) | 32'(owe));
        write_reg(int'(slm_pkg::REG_LOW),   ($urandom() & 32'hFFFF_0000) | 32'(low));
        write_reg(int'(slm_pkg::REG_CUT),   ($urandom() & 32'hFFFF_0000) | 32'(cut));
        write_reg(int'(slm_pkg::REG_HYS),   ($urandom() & 32'hFFFF_F000) | 32'(hys));
        write_reg(int'(slm_pkg::REG_START), ($urandom() & 32'hFFFF_0000) | 32'(start));
    endtask

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            IDLE_SRC:  begin src_idle_pct = 72; snk_stall_pct = 0;  end
            IDLE_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 72; end
            default:   begin src_idle_pct = 15; snk_stall_pct = 15; end
        endcase
    endtask

    task automatic add_sample(input int mv, input logic busy);
        t_sample_item it;
        it.mv = slm_pkg::t_mv'(mv);
        it.busy = busy;
        pending_samples.push_back(it);
    endtask

    // wait until every queued sample went in and every result came back
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_samples.size() != 0 || smp.valid || expected_levels.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // samples cluster around thresholds and their hysteresis edges
    function automatic int pick_sample();
        int sel;
        int base;
        int off;
        int m;
        int v;
        m = int'(hys_mrg);
        sel = int'($urandom_range(99));
        if (sel < 12) begin
            v = int'($urandom_range(65535));
        end else if (sel < 16) begin
            v = $urandom_range(1) ? 65535 : 0;
        end else begin
            case ($urandom_range(3))
                0: base = int'(owe_thr);
                1: base = int'(low_thr);
                2: base = int'(cut_thr);
                default: base = int'(start_thr);
            endcase
            case ($urandom_range(3))
                0: off = int'($urandom_range(2)) - 1;
                1: off = m + int'($urandom_range(2)) - 1;
                2: off = -m + int'($urandom_range(2)) - 1;
                default: off = int'($urandom_range(2 * m + 20)) - (m + 10);
            endcase
            v = base + off;
        end
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v;
    endfunction

    task automatic fill_random(input int count);
        int   n;
        int   run;
        int   v;
        logic busy;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 80) begin
                // repeated runs are what let candidates commit
                run = int'($urandom_range(3, 1));
                v = pick_sample();
                busy = ($urandom_range(99) < 25);
                for (int k = 0; k < run && n < count; k++) begin
                    add_sample(v, busy);
                    n++;
                end
            end else begin
                add_sample(int'($urandom_range(65535)), 1'($urandom_range(1)));
                n++;
            end
        end
    endtask

    task automatic config_for_phase(input int p);
        int a;
        int b;
        int c;
        int t;
        a = int'($urandom_range(65535));
        b = int'($urandom_range(65535));
        c = int'($urandom_range(65535));
        if (a < b) begin t = a; a = b; b = t; end
        if (b < c) begin t = b; b = c; c = t; end
        if (a < b) begin t = a; a = b; b = t; end
        case (p)
            0: set_thresholds(3300, 3000, 2700, 50, 3000);
            1: set_thresholds(a, b, c, int'($urandom_range(600)),
                              int'($urandom_range(65535)));
            2: set_thresholds(0, 0, 0, 0, 0);
            3: set_thresholds(65535, 65535, 65535, 4095, 65535);
            4: set_thresholds(1000, 3000, 2000, 300, 1500);    // misordered
            5: set_thresholds(40000, 30000, 20000, 4095, 10000);
            6: set_thresholds(a, b, c, int'($urandom_range(4095)),
                              int'($urandom_range(65535)));
            default: set_thresholds(int'($urandom_range(65535)), int'($urandom_range(65535)),
                                    int'($urandom_range(65535)), int'($urandom_range(4095)),
                                    int'($urandom_range(65535)));
        endcase
        // indexes past the last register must be ignored
        if (p == 2 || p == 5) begin
            for (int k = int'(slm_pkg::REG_START) + 1; k <= REG_IDX_MAX; k++)
                write_reg(k, $urandom());
        end
    endtask

    // -------------------------------------------------------------------- main
    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        smp.valid = 1'b0;
        smp.sample_mv = '0;
        smp.link_busy = 1'b0;
        res.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through the level graph on reset thresholds
        set_idle_mode(IDLE_NONE);
        add_sample(0, 1'b0);        // below start, stays unknown
        add_sample(2999, 1'b1);
        add_sample(3000, 1'b0);     // exactly start: leaves unknown
        add_sample(3301, 1'b0);
        add_sample(3250, 1'b0);     // owe candidate
        add_sample(3250, 1'b1);     // busy holds normal, count clears
        add_sample(3250, 1'b0);
        add_sample(3250, 1'b0);
        add_sample(3350, 1'b0);     // on the upper hysteresis edge
        add_sample(3351, 1'b0);
        add_sample(3100, 1'b1);
        add_sample(2700, 1'b1);     // busy does not block cut
        add_sample(2750, 1'b0);
        add_sample(2751, 1'b0);
        add_sample(3050, 1'b0);
        add_sample(3051, 1'b0);
        add_sample(2950, 1'b0);
        add_sample(3200, 1'b0);     // back to committed level, count clears
        add_sample(2950, 1'b1);
        add_sample(2950, 1'b0);
        add_sample(2950, 1'b0);
        add_sample(2650, 1'b0);
        add_sample(65535, 1'b0);
        add_sample(3100, 1'b0);
        add_sample(2900, 1'b0);     // candidate replaced by a one-sample move
        add_sample(0, 1'b0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            config_for_phase(p);
            set_idle_mode(t_idle_mode'((p + 1) % 4));
            fill_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (5) @(posedge i_clk);
        if (expected_levels.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", expected_levels.size()));
        end
        $display("ran %0d samples through %0d threshold sets, %0d results checked",
                 n_accepted, PHASES + 1, n_checked);
        $display("saw %0d level changes, %0d power-off and %0d power-on events",
                 n_changes, n_pwr_off, n_pwr_on);
        $display("%0d mismatches", mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
